@@ hw/rtl/dswf_pkg.sv @@
// Package for the duplicate serial window filter.
// Holds status codes and the result struct; no dependencies.
package dswf_pkg;

    localparam int STATUS_BITS = 3;

    localparam logic [STATUS_BITS-1:0] ST_ADVANCED       = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_NEW_IN_WINDOW  = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_EQUALS_HIGHEST = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_SEEN           = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_TOO_OLD        = 3'd4;

    typedef struct packed {
        logic                   accept;
        logic [STATUS_BITS-1:0] status;
    } t_result;

endpackage

@@ hw/rtl/dswf_in_if.sv @@
// Request channel carrying one packet serial per request.
// Depends on nothing.
interface dswf_in_if #(
    parameter int SERIAL_BITS = 31
);
    logic                   valid;
    logic                   ready;
    logic [SERIAL_BITS-1:0] serial;

    modport source (output valid, output serial, input ready);
    modport sink   (input valid, input serial, output ready);
endinterface

@@ hw/rtl/dswf_out_if.sv @@
// Result channel carrying the accept flag and status code.
// Depends on dswf_pkg.
interface dswf_out_if;
    logic                             valid;
    logic                             ready;
    logic                             accept;
    logic [dswf_pkg::STATUS_BITS-1:0] status;

    modport source (output valid, output accept, output status, input ready);
    modport sink   (input valid, input accept, input status, output ready);
endinterface

@@ hw/rtl/dswf_check.sv @@
// Combinational window decision: classifies a serial against the highest
// serial and seen bitmap and produces the next state. Depends on dswf_pkg.
module dswf_check #(
    parameter int WINDOW_BITS = 8,
    parameter int SERIAL_BITS = 31
) (
    input  logic [SERIAL_BITS-1:0] i_serial,
    input  logic [SERIAL_BITS-1:0] i_highest,
    input  logic [WINDOW_BITS-1:0] i_window,
    output logic [SERIAL_BITS-1:0] o_highest,
    output logic [WINDOW_BITS-1:0] o_window,
    output dswf_pkg::t_result      o_result
);
    localparam int DW = $clog2(WINDOW_BITS + 1);

    logic [SERIAL_BITS-1:0] up_dist;
    logic [SERIAL_BITS-1:0] down_dist;
    logic                   is_above;
    logic                   is_equal;
    logic                   near_up;
    logic                   near_down;
    logic [DW-1:0]          dist_s;
    logic [DW-1:0]          pos;
    logic [WINDOW_BITS-1:0] onehot;
    logic [WINDOW_BITS-1:0] shifted;
    logic                   hit;

    assign up_dist   = i_serial - i_highest;
    assign down_dist = i_highest - i_serial;
    assign is_above  = i_serial > i_highest;
    assign is_equal  = i_serial == i_highest;
    assign near_up   = up_dist <= SERIAL_BITS'(WINDOW_BITS);
    assign near_down = down_dist <= SERIAL_BITS'(WINDOW_BITS);
    assign dist_s    = is_above ? up_dist[DW-1:0] : down_dist[DW-1:0];
    assign pos       = DW'(WINDOW_BITS) - dist_s;
    assign shifted   = i_window >> up_dist[DW-1:0];
    assign hit       = |(i_window & onehot);

    always_comb begin
        for (int i = 0; i < WINDOW_BITS; i++) begin
            onehot[i] = (pos == DW'(i));
        end
    end

    always_comb begin
        o_highest = i_highest;
        o_window  = i_window;
        if (is_above) begin
            o_highest = i_serial;
            o_window  = near_up ? (shifted | onehot) : '0;
            o_result  = '{accept: 1'b1, status: dswf_pkg::ST_ADVANCED};
        end else if (is_equal) begin
            o_result  = '{accept: 1'b0, status: dswf_pkg::ST_EQUALS_HIGHEST};
        end else if (near_down) begin
            if (hit) begin
                o_result = '{accept: 1'b0, status: dswf_pkg::ST_SEEN};
            end else begin
                o_window = i_window | onehot;
                o_result = '{accept: 1'b1, status: dswf_pkg::ST_NEW_IN_WINDOW};
            end
        end else begin
            o_result  = '{accept: 1'b0, status: dswf_pkg::ST_TOO_OLD};
        end
    end
endmodule

@@ hw/rtl/duplicate_serial_window_filter_unit.sv @@
// Duplicate serial window filter top level: input register, window state,
// result register. Depends on dswf_pkg, dswf_in_if, dswf_out_if, dswf_check.
//
// Usage:
//   i_req carries one packet serial per request; o_rsp returns one result
//   per request: accept (forward the packet) and a status code.
//   A request is taken when valid and ready are high at a rising edge.
//   Path from request to result: input register, then the window check
//   writes the result register and the state together.
//   Throughput: one request per cycle while the receiver takes results;
//   the window check is combinational subtract, compare, shift and bit
//   set, so back-to-back serials see each other's updates.
//   When the receiver stalls, the result register holds and the input
//   register fills; i_req.ready drops only when both are full.
//   Reset (synchronous, active low) empties both registers and clears the
//   highest serial to zero and the seen bitmap to all zeros.
module duplicate_serial_window_filter_unit #(
    parameter int WINDOW_BITS = 8,
    parameter int SERIAL_BITS = 31
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dswf_in_if.sink    i_req,
    dswf_out_if.source o_rsp
);
    logic                   r_s1_valid;
    logic [SERIAL_BITS-1:0] r_serial;
    logic                   r_out_valid;
    dswf_pkg::t_result      r_out;
    logic [SERIAL_BITS-1:0] r_highest;
    logic [WINDOW_BITS-1:0] r_window;

    logic [SERIAL_BITS-1:0] n_highest;
    logic [WINDOW_BITS-1:0] n_window;
    dswf_pkg::t_result      n_out;
    logic                   s1_fire;
    logic                   in_fire;

    dswf_check #(
        .WINDOW_BITS (WINDOW_BITS),
        .SERIAL_BITS (SERIAL_BITS)
    ) u_check (
        .i_serial  (r_serial),
        .i_highest (r_highest),
        .i_window  (r_window),
        .o_highest (n_highest),
        .o_window  (n_window),
        .o_result  (n_out)
    );

    assign s1_fire     = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_fire;
    assign in_fire     = i_req.valid && i_req.ready;

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.accept = r_out.accept;
    assign o_rsp.status = r_out.status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_highest   <= '0;
            r_window    <= '0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
                r_highest   <= n_highest;
                r_window    <= n_window;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_serial <= i_req.serial;
        end
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

    // accept only for the two "new" outcomes
    a_accept_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.accept == (r_out.status == dswf_pkg::ST_ADVANCED ||
                                          r_out.status == dswf_pkg::ST_NEW_IN_WINDOW)))
        else $error("accept flag disagrees with status");

    a_highest_monotonic: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n)) |-> (r_highest >= $past(r_highest)))
        else $error("highest serial decreased");

    a_advance_sets_highest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && n_out.status == dswf_pkg::ST_ADVANCED) |=> (r_highest == $past(r_serial)))
        else $error("advance did not load highest serial");

    a_drop_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && !n_out.accept) |=> ($stable(r_window) && $stable(r_highest)))
        else $error("dropped request changed window state");
endmodule
